>>> hw/rtl/bis_pkg.sv
// shared types and constants for the bounded integer stack
// no dependencies; imported by bis_cell, bis_ctrl and the top level
package bis_pkg;

   localparam int DEPTH = 64;
   localparam int DATA_W = 32;
   localparam int CMD_W = 3;
   localparam int STAT_W = 2;
   localparam int LIM_W = 7;
   localparam int FOUND_W = 6;
   localparam int FILL_W = 7;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
   localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_PEEK   = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_SEARCH = 3'd4,
      CMD_STATUS = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_SCAN  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   // one shift/compare command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
      logic match_load;
      logic scan;
   } cell_ctl_type;

endpackage

>>> hw/rtl/bis_cell.sv
// one stack cell: holds an entry and a match bit, shifts with its neighbors
// depends on bis_pkg
module bis_cell import bis_pkg::*; (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [DATA_W-1:0] above_entry,
   input  logic [DATA_W-1:0] below_entry,
   input  logic              below_match,
   input  logic [DATA_W-1:0] search_key,
   output logic [DATA_W-1:0] entry,
   output logic              match
);

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         entry_in = above_entry;
      end else if (ctl.pop) begin
         entry_in = below_entry;
      end
   end

   // match bits move toward the top one cell per cycle during a scan
   always_comb begin
      match_in = match_ff;
      if (ctl.match_load) begin
         match_in = (entry_ff == search_key);
      end else if (ctl.scan) begin
         match_in = below_match;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

>>> hw/rtl/bis_ctrl.sv
// command sequencer: fill count, limit register, search scan and response register
// depends on bis_pkg; drives the cell chain through cell_ctl_type
module bis_ctrl import bis_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_command,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic signed [DATA_W-1:0] rsp_data_out,
   output logic [FOUND_W-1:0]  rsp_found_position,
   output logic [FILL_W-1:0]   rsp_fill_count,
   output logic                rsp_is_empty,
   output logic                rsp_is_full,
   input  logic                csr_write_enable,
   input  logic [LIM_W-1:0]    csr_write_data,
   input  logic [DATA_W-1:0]   head_entry,
   input  logic                head_match,
   output cell_ctl_type        cell_ctl,
   output logic [DATA_W-1:0]   search_key
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              hit_ff, hit_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_full_ff, rsp_full_in;

   cmd_type           cmd;
   logic              slot_free;
   logic              req_fire;
   logic              full_now;
   logic              load;
   status_type        ld_status;
   logic [DATA_W-1:0] ld_data;
   logic [IDX_W-1:0]  ld_pos;

   assign cmd       = cmd_type'(req_command);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign full_now  = (CMP_W'(count_ff) >= CMP_W'(limit_ff))
                      || (CMP_W'(count_ff) >= CMP_W'(DEPTH));

   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      key_in    = key_ff;
      cell_ctl  = '0;
      load      = 1'b0;
      ld_status = STAT_OK;
      ld_data   = '0;
      ld_pos    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_PUSH: begin
                     load = 1'b1;
                     if (full_now) begin
                        ld_status = STAT_FULL;
                     end else begin
                        cell_ctl.push = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     load = 1'b1;
                     if (count_ff == '0) begin
                        ld_status = STAT_EMPTY;
                     end else begin
                        ld_data = head_entry;
                        if (cmd == CMD_POP) begin
                           cell_ctl.pop = 1'b1;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     load = 1'b1;
                     count_in = '0;
                  end
                  CMD_SEARCH: begin
                     key_in = req_value;
                     state_in = S_MATCH;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_MATCH: begin
            cell_ctl.match_load = 1'b1;
            scan_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // head cell sees the match bit of the entry scan_ff below the top
            if (scan_ff == count_ff) begin
               hit_in = 1'b0;
               state_in = S_DONE;
            end else if (head_match) begin
               hit_in = 1'b1;
               pos_in = IDX_W'(count_ff - scan_ff - 1'b1);
               state_in = S_DONE;
            end else begin
               cell_ctl.scan = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               load = 1'b1;
               ld_status = hit_ff ? STAT_OK : STAT_NOTFOUND;
               ld_pos = hit_ff ? pos_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ld_status;
         rsp_data_in   = ld_data;
         rsp_pos_in    = ld_pos;
         rsp_fill_in   = count_in;
         rsp_empty_in  = (count_in == '0);
         rsp_full_in   = (CMP_W'(count_in) >= CMP_W'(limit_ff))
                         || (CMP_W'(count_in) >= CMP_W'(DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      hit_ff        <= hit_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign search_key         = key_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_found_position = FOUND_W'(rsp_pos_ff);
   assign rsp_fill_count     = FILL_W'(rsp_fill_ff);
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_is_full        = rsp_full_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("fill count above depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_ff <= count_ff)
      else $error("scan ran past fill count");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && cmd == CMD_PUSH && !full_now |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted push did not grow the stack");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && hit_ff |-> CNT_W'(pos_ff) < count_ff)
      else $error("search hit outside held entries");

   a_no_word_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_fire)
      else $error("word accepted during search");
`endif

endmodule

>>> hw/rtl/bounded_integer_stack_core.sv
// Bounded LIFO stack of 32-bit signed words built as a chain of shift cells, top in cell 0.
// Push, pop, peek, clear and status load the response register when accepted and may follow
// back to back while the response register drains; a search holds the request port until it
// ends (the key is registered on acceptance, S_MATCH runs one compare in every cell, S_SCAN
// shifts match bits up the chain until the first hit or the last held entry, and S_DONE posts
// the response once the response register is free). The stack_limit register is written through
// csr_write_enable/csr_write_data; the user must write it only while the stack is idle, which
// the block itself does not enforce. Depends on bis_pkg, bis_cell and bis_ctrl.
module bounded_integer_stack_core import bis_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_data_out,
   output logic [FOUND_W-1:0]       rsp_found_position,
   output logic [FILL_W-1:0]        rsp_fill_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   input  logic                     csr_write_enable,
   input  logic [LIM_W-1:0]         csr_write_data
);

   cell_ctl_type      cell_ctl;
   logic [DATA_W-1:0] search_key;
   logic [DATA_W-1:0] cell_entry [DEPTH];
   logic              cell_match [DEPTH];

   bis_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_found_position (rsp_found_position),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .head_entry         (cell_entry[0]),
      .head_match         (cell_match[0]),
      .cell_ctl           (cell_ctl),
      .search_key         (search_key)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] above;
      logic [DATA_W-1:0] below;
      logic              below_m;

      // new word enters at the top; the bottom cell refills from itself on pop
      if (i == 0) begin : g_top
         assign above = req_value;
      end else begin : g_mid
         assign above = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_bottom
         assign below   = cell_entry[i];
         assign below_m = 1'b0;
      end else begin : g_inner
         assign below   = cell_entry[i+1];
         assign below_m = cell_match[i+1];
      end

      bis_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .above_entry (above),
         .below_entry (below),
         .below_match (below_m),
         .search_key  (search_key),
         .entry       (cell_entry[i]),
         .match       (cell_match[i])
      );
   end

endmodule
